/* hw/rtl/adi_pkg.sv */
// Shared types and constants for the three-axis acceleration double integrator.
`timescale 1ns / 1ps

package adi_pkg;

    localparam int ACCEL_BITS_DEF = 18;
    localparam int ACC_BITS_DEF   = 32;
    localparam int AXES           = 3;
    localparam int OUT_BITS       = 32;
    localparam int RUN_BITS       = 8;
    localparam int THR_BITS       = 8;
    localparam int M_DATA_BITS    = 2 * AXES * OUT_BITS;

    localparam logic [THR_BITS-1:0] STILL_DEFAULT = THR_BITS'(25);
    localparam logic [RUN_BITS-1:0] RUN_MAX       = {RUN_BITS{1'b1}};

    typedef struct packed {
        logic                step;
        logic [THR_BITS-1:0] thr;
    } t_axis_ctl;

endpackage

/* hw/rtl/adi_axis.sv */
// One axis of the trapezoidal double integrator with its state and zero-run counter.
`timescale 1ns / 1ps

module adi_axis import adi_pkg::*; #(
    parameter int ACCEL_BITS = ACCEL_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_axis_ctl                    i_ctl,
    input  logic signed [ACCEL_BITS-1:0] i_accel,
    output logic signed [OUT_BITS-1:0]   o_vel,
    output logic signed [OUT_BITS-1:0]   o_disp
);

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic signed [ACCEL_BITS-1:0] r_prev;
    logic signed [ACC_BITS-1:0]   r_vel;
    logic signed [ACC_BITS-1:0]   r_disp;
    logic        [RUN_BITS-1:0]   r_run;

    logic signed [ACCEL_BITS:0]   w_asum;
    logic signed [ACCEL_BITS-1:0] w_ahalf;
    logic signed [ACC_BITS:0]     w_vsum;
    logic signed [ACC_BITS-1:0]   w_vnew;
    logic signed [ACC_BITS:0]     w_vpair;
    logic signed [ACC_BITS-1:0]   w_vhalf;
    logic signed [ACC_BITS:0]     w_dsum;
    logic signed [ACC_BITS-1:0]   w_dnew;
    logic signed [63:0]           w_vext;
    logic signed [63:0]           w_dext;
    logic        [RUN_BITS-1:0]   n_run;
    logic signed [ACC_BITS-1:0]   n_vel;

    always_comb begin
        w_asum  = $signed({r_prev[ACCEL_BITS-1], r_prev}) +
                  $signed({i_accel[ACCEL_BITS-1], i_accel});
        w_ahalf = w_asum[ACCEL_BITS:1];
        w_vsum  = $signed({r_vel[ACC_BITS-1], r_vel}) + $signed((ACC_BITS+1)'(w_ahalf));
        if (w_vsum[ACC_BITS] != w_vsum[ACC_BITS-1]) begin
            w_vnew = w_vsum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            w_vnew = w_vsum[ACC_BITS-1:0];
        end
        w_vpair = $signed({r_vel[ACC_BITS-1], r_vel}) + $signed({w_vnew[ACC_BITS-1], w_vnew});
        w_vhalf = w_vpair[ACC_BITS:1];
        w_dsum  = $signed({r_disp[ACC_BITS-1], r_disp}) +
                  $signed({w_vhalf[ACC_BITS-1], w_vhalf});
        if (w_dsum[ACC_BITS] != w_dsum[ACC_BITS-1]) begin
            w_dnew = w_dsum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            w_dnew = w_dsum[ACC_BITS-1:0];
        end
        w_vext = 64'(w_vnew);
        w_dext = 64'(w_dnew);

        if (i_accel != '0) begin
            n_run = '0;
        end else if (r_run != RUN_MAX) begin
            n_run = r_run + RUN_BITS'(1);
        end else begin
            n_run = r_run;
        end
        n_vel = (n_run >= i_ctl.thr) ? '0 : w_vnew;
    end

    assign o_vel  = w_vext[OUT_BITS-1:0];
    assign o_disp = w_dext[OUT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_vel  <= '0;
            r_disp <= '0;
            r_run  <= '0;
        end else if (i_ctl.step) begin
            r_prev <= i_accel;
            r_vel  <= n_vel;
            r_disp <= w_dnew;
            r_run  <= n_run;
        end
    end

endmodule

/* hw/rtl/accel_double_integrator_zero_vel.sv */
// Top level of the three-axis acceleration double integrator with zero-velocity reset.
// The slave stream carries one three-axis acceleration sample per transfer. Each
// transfer is latched in an input register; from there one pass of add, halve and
// saturate logic per axis yields velocity and displacement, which are captured in
// the output register and presented on the master stream, one result per sample.
// One sample can be accepted every cycle while the receiver does not stall; that
// rate is set by the combinational per-axis integrator, whose state is updated
// when a result moves into the output register. While the receiver stalls, the
// result holds in the output register and one more sample waits in the input
// register; o_s_tready then drops until the result is taken. The still threshold
// is written through the cfg channel, which is always ready and should be written
// only while no sample is in flight. Synchronous reset clears both registers'
// valid flags, all axis state and the zero run counters, and restores the still
// threshold to 25.
`timescale 1ns / 1ps

module accel_double_integrator_zero_vel import adi_pkg::*; #(
    parameter int ACCEL_BITS = ACCEL_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF,
    localparam int S_DATA_BITS = ((AXES * ACCEL_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // Fields from the lowest bit: accel_x, accel_y, accel_z, zero fill.
    input  logic [S_DATA_BITS-1:0] i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // Fields from the lowest bit: vel_x, vel_y, vel_z, disp_x, disp_y, disp_z.
    output logic [M_DATA_BITS-1:0] o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [THR_BITS-1:0]    i_cfg_data
);

    logic                         r_in_valid;
    logic signed [ACCEL_BITS-1:0] r_accel [AXES];
    logic                         r_out_valid;
    logic signed [OUT_BITS-1:0]   r_vel   [AXES];
    logic signed [OUT_BITS-1:0]   r_disp  [AXES];
    logic        [THR_BITS-1:0]   r_thr;

    logic                         w_advance;
    logic                         w_s_xfer;
    t_axis_ctl                    w_ctl;
    logic signed [OUT_BITS-1:0]   w_vel   [AXES];
    logic signed [OUT_BITS-1:0]   w_disp  [AXES];

    assign w_advance   = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || w_advance;
    assign w_s_xfer    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_ctl.step  = w_advance;
    assign w_ctl.thr   = r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= STILL_DEFAULT;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            for (int k = 0; k < AXES; k++) begin
                r_accel[k] <= i_s_tdata[k*ACCEL_BITS +: ACCEL_BITS];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < AXES; g++) begin : g_axis
            adi_axis #(
                .ACCEL_BITS (ACCEL_BITS),
                .ACC_BITS   (ACC_BITS)
            ) u_axis (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_accel (r_accel[g]),
                .o_vel   (w_vel[g]),
                .o_disp  (w_disp[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            for (int k = 0; k < AXES; k++) begin
                r_vel[k]  <= w_vel[k];
                r_disp[k] <= w_disp[k];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            o_m_tdata[k*OUT_BITS +: OUT_BITS]          = r_vel[k];
            o_m_tdata[(AXES+k)*OUT_BITS +: OUT_BITS]   = r_disp[k];
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_accel[0])
            && $stable(r_accel[1]) && $stable(r_accel[2]))
        else $error("Waiting sample changed or was dropped.");

    a_advance_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_m_tvalid)
        else $error("Result transfer did not reach the output register.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_s_tready)
        else $error("Input register empty but slave side not ready.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !w_advance)
        else $error("Stalled result overwritten.");

endmodule
